// ===== sv/okm_pkg.sv =====
package okm_pkg;
	localparam int MaxClusters = 64;
	localparam int MaxDim = 16;
	localparam int ClW = 6;
	localparam int ElW = 4;
	localparam int AddrW = ClW + ElW;
	localparam int CentDepth = MaxClusters * MaxDim;
	localparam int ValW = 16;
	localparam int CntW = 32;
	localparam int DistW = 36;
	localparam int KW = 7;
	localparam int LenW = 5;
	localparam int CfgW = 7;

	localparam logic [1:0] CMD_CENT = 2'd0;
	localparam logic [1:0] CMD_COUNT = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	localparam logic CFG_CLUSTERS = 1'b0;
	localparam logic CFG_LENGTH = 1'b1;

	localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
	localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

	typedef struct packed {
		logic [1:0] cmd;
		logic [ClW-1:0] cluster_index;
		logic [ElW-1:0] element_index;
		logic signed [ValW-1:0] element_value;
		logic [CntW-1:0] count_value;
		logic last_element;
	} in_item_t;

	typedef struct packed {
		logic [ClW-1:0] winner_cluster;
		logic [CntW-1:0] winner_count;
		logic [DistW-1:0] nearest_distance;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic dist_clear;   // start new distance sum
		logic dist_acc;     // accumulate read data
		logic dist_close;   // compare sum with best
		logic first_cl;     // closing cluster 0
		logic upd_rd;       // read winner centroid elem
		logic div_start;    // start divide on read data
		logic upd_wr;       // write quotient back
		logic cnt_bump;     // increment winner count
		logic res_load;     // capture result into output register
		logic [ClW-1:0] cl;
		logic [ElW-1:0] el;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic [ClW-1:0] best;
	} sts_t;
endpackage

// ===== sv/okm_if.sv =====
interface okm_if #(parameter type item_t = logic);
	logic valid;
	logic ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/okm_ram.sv =====
module okm_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/okm_div.sv =====
// Signed 17-bit dividend by unsigned 32-bit divisor, restoring, one bit a cycle.
module okm_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [16:0] num,
	input logic [okm_pkg::CntW-1:0] den,
	output logic done,
	output logic signed [16:0] quo
);
	import okm_pkg::*;
	logic busy_q;
	logic [4:0] cnt_q;
	logic neg_q;
	logic [16:0] mag_q;
	logic [16:0] q_q;
	logic [CntW:0] rem_q;
	logic [CntW-1:0] den_q;
	logic [CntW:0] trial;
	logic [16:0] num_abs;

	assign num_abs = num[16] ? 17'(-num) : num;
	assign trial = {rem_q[CntW-1:0], mag_q[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[16];
			mag_q <= num_abs;
			den_q <= den;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[15:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				q_q <= {q_q[15:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[15:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? 17'(-q_q) : q_q;
endmodule

// ===== sv/okm_datapath.sv =====
module okm_datapath (
	input logic clk,
	input logic arst_n,
	input okm_pkg::in_item_t item,
	input logic load_cent,
	input logic load_count,
	input logic load_sample,
	input okm_pkg::ctl_t ctl,
	output okm_pkg::sts_t sts,
	output okm_pkg::out_item_t result
);
	import okm_pkg::*;

	logic signed [ValW-1:0] sample_q [MaxDim];
	logic [MaxClusters-1:0] cnt_set_q;
	logic [CntW-1:0] cnt_rd;
	logic [CntW-1:0] cnt_inc;
	logic [CntW-1:0] n_q;

	logic cnt_we;
	logic [ClW-1:0] cnt_waddr;
	logic [CntW-1:0] cnt_wdata, cnt_rdata;

	logic ram_we;
	logic [AddrW-1:0] ram_waddr, ram_raddr;
	logic [ValW-1:0] ram_wdata, ram_rdata;

	logic [ElW-1:0] el_s1, el_s2;
	logic signed [ValW-1:0] cent_q;
	logic signed [16:0] diff;
	logic signed [33:0] sq;
	logic [33:0] sq_s2;
	logic acc_s1, acc_s2;
	logic [DistW-1:0] sum_q, best_d_q;
	logic [DistW:0] sum_next;
	logic [ClW-1:0] best_q;
	out_item_t res_q;
	logic div_done;
	logic signed [16:0] quo;

	assign ram_raddr = {ctl.cl, ctl.el};
	okm_ram #(.Width(ValW), .Depth(CentDepth)) u_cent (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	always_comb begin
		ram_we = load_cent;
		ram_waddr = {item.cluster_index, item.element_index};
		ram_wdata = item.element_value;
		if (ctl.upd_wr) begin
			ram_we = 1'b1;
			ram_waddr = {best_q, el_s2};
			ram_wdata = ValW'(cent_q + quo);
		end
	end

	// unwritten counts read as one
	assign cnt_rd = cnt_set_q[best_q] ? cnt_rdata : CntW'(1);
	assign cnt_inc = (cnt_rd == CountMax) ? cnt_rd : cnt_rd + 1'b1;

	always_comb begin
		cnt_we = load_count;
		cnt_waddr = item.cluster_index;
		cnt_wdata = item.count_value;
		if (ctl.cnt_bump) begin
			cnt_we = 1'b1;
			cnt_waddr = best_q;
			cnt_wdata = cnt_inc;
		end
	end

	okm_ram #(.Width(CntW), .Depth(MaxClusters)) u_cnt (
		.clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(best_q), .rdata(cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_set_q <= '0;
			acc_s1 <= 1'b0;
			acc_s2 <= 1'b0;
		end else begin
			acc_s1 <= ctl.dist_acc;
			acc_s2 <= acc_s1;
			if (load_count) cnt_set_q[item.cluster_index] <= 1'b1;
			if (ctl.cnt_bump) cnt_set_q[best_q] <= 1'b1;
		end
	end

	assign diff = 17'(sample_q[el_s1]) - 17'($signed(ram_rdata));
	assign sq = diff * diff;
	assign sum_next = {1'b0, sum_q} + 37'(sq_s2);

	always_ff @(posedge clk) begin
		if (load_sample) sample_q[item.element_index] <= item.element_value;
		el_s1 <= ctl.el;
		if (ctl.dist_acc) el_s2 <= el_s1;
		sq_s2 <= $unsigned(sq);
		if (ctl.dist_clear) sum_q <= '0;
		else if (acc_s2) sum_q <= sum_next[DistW] ? DistMax : sum_next[DistW-1:0];
		if (ctl.dist_close) begin
			if (ctl.first_cl || sum_q < best_d_q) begin
				best_d_q <= sum_q;
				best_q <= ctl.cl;
			end
		end
		if (ctl.cnt_bump) n_q <= cnt_inc;
		if (ctl.div_start) begin
			cent_q <= ram_rdata;
			el_s2 <= el_s1;
		end
		if (ctl.res_load) begin
			res_q.winner_cluster <= best_q;
			res_q.winner_count <= n_q;
			res_q.nearest_distance <= best_d_q;
		end
	end

	okm_div u_div (
		.clk, .arst_n, .start(ctl.div_start),
		.num(diff),
		.den(n_q), .done(div_done), .quo
	);

	assign sts.div_done = div_done;
	assign sts.best = best_q;
	assign result = res_q;
endmodule

// ===== sv/okm_ctrl.sv =====
module okm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [okm_pkg::KW-1:0] k,
	input logic [okm_pkg::LenW-1:0] len,
	input okm_pkg::sts_t sts,
	input logic out_ready,
	output logic busy,
	output logic out_valid,
	output okm_pkg::ctl_t ctl
);
	import okm_pkg::*;
	typedef enum logic [3:0] {
		S_IDLE, S_DIST, S_DRAIN, S_CRD, S_BUMP, S_URD, S_UDIV, S_UWAIT, S_OUT
	} state_t;
	state_t state_q;
	logic [ClW-1:0] cl_q;
	logic [ElW-1:0] el_q;
	logic [1:0] drain_q;
	logic out_valid_q;
	logic res_load;
	logic [ClW-1:0] last_cl;
	logic [ElW-1:0] last_el;

	assign last_cl = ClW'(k - 7'd1);
	assign last_el = ElW'(len - 5'd1);
	assign busy = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	// load the output register once the previous result has left
	assign res_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		ctl = '0;
		ctl.cl = cl_q;
		ctl.el = el_q;
		ctl.res_load = res_load;
		unique case (state_q)
			S_DIST: begin
				ctl.dist_acc = 1'b1;
				ctl.dist_clear = (el_q == '0) && (drain_q == '0);
			end
			S_DRAIN: begin
				ctl.dist_close = drain_q == 2'd3;
				ctl.first_cl = cl_q == '0;
			end
			S_CRD: ctl.cl = sts.best;
			S_BUMP: begin
				ctl.cnt_bump = 1'b1;
				ctl.cl = sts.best;
			end
			S_URD: ctl.cl = sts.best;
			S_UDIV: begin
				ctl.cl = sts.best;
				ctl.div_start = 1'b1;
			end
			S_UWAIT: begin
				ctl.cl = sts.best;
				ctl.upd_wr = sts.div_done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cl_q <= '0;
			el_q <= '0;
			drain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_DIST;
					cl_q <= '0;
					el_q <= '0;
					drain_q <= '0;
				end
				S_DIST: begin
					if (el_q == last_el) begin
						state_q <= S_DRAIN;
						drain_q <= 2'd1;
					end else el_q <= el_q + 1'b1;
				end
				S_DRAIN: begin
					// wait for read, square and sum stages
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd3) begin
						drain_q <= '0;
						el_q <= '0;
						if (cl_q == last_cl) state_q <= S_CRD;
						else begin
							cl_q <= cl_q + 1'b1;
							state_q <= S_DIST;
						end
					end
				end
				// wait for the winner's count read
				S_CRD: state_q <= S_BUMP;
				S_BUMP: begin
					el_q <= '0;
					state_q <= S_URD;
				end
				S_URD: state_q <= S_UDIV;
				S_UDIV: state_q <= S_UWAIT;
				S_UWAIT: if (sts.div_done) begin
					if (el_q == last_el) state_q <= S_OUT;
					else begin
						el_q <= el_q + 1'b1;
						state_q <= S_URD;
					end
				end
				S_OUT: if (res_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/online_kmeans_update_unit.sv =====
// Online k-means centroid update.
// in_ch carries commands: centroid element load, cluster count load and sample
// elements. Loads and non-final sample elements only write storage.
// A sample element with last_element set starts a search over clusters_in_use
// centroids of vector_length elements: one element a cycle from the centroid
// RAM plus a drain of the read, square and sum stages per cluster, then a read
// and bump of the winner's count, then each element is moved by a serial
// divider. From the transfer of the last element until the result is loaded
// for out_ch, in_ch is not ready.
// The result sits in an output register until taken, so in_ch accepts again
// while the receiver stalls; a following search waits at its end until that
// register is free. Reset sets clusters_in_use to 1, vector_length to 16 and
// every cluster count to one; centroid and sample storage holds whatever was
// last written. Configuration must be written through cfg_we, cfg_index and
// cfg_data only while idle; the block itself does not enforce this.
module online_kmeans_update_unit (
	input logic clk,
	input logic arst_n,
	okm_if.sink in_ch,
	okm_if.source out_ch,
	input logic cfg_we,
	input logic cfg_index,
	input logic [okm_pkg::CfgW-1:0] cfg_data
);
	import okm_pkg::*;
	logic [KW-1:0] k_q;
	logic [LenW-1:0] len_q;
	logic [KW-1:0] k_eff;
	logic [LenW-1:0] len_eff;
	logic busy, acc, start;
	ctl_t ctl;
	sts_t sts;
	in_item_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KW'(1);
			len_q <= LenW'(16);
		end else if (cfg_we) begin
			if (cfg_index == CFG_CLUSTERS) k_q <= cfg_data[KW-1:0];
			else len_q <= cfg_data[LenW-1:0];
		end
	end

	assign k_eff = (k_q == '0) ? KW'(1) : (k_q > KW'(MaxClusters)) ? KW'(MaxClusters) : k_q;
	assign len_eff = (len_q == '0) ? LenW'(1)
		: (len_q > LenW'(MaxDim)) ? LenW'(MaxDim) : len_q;

	assign item = in_ch.data;
	assign in_ch.ready = !busy;
	assign acc = in_ch.valid && !busy;
	assign start = acc && item.cmd == CMD_SAMPLE && item.last_element;

	okm_ctrl u_ctrl (
		.clk, .arst_n, .start, .k(k_eff), .len(len_eff), .sts,
		.out_ready(out_ch.ready), .busy, .out_valid(out_ch.valid), .ctl
	);

	okm_datapath u_dp (
		.clk, .arst_n, .item,
		.load_cent(acc && item.cmd == CMD_CENT),
		.load_count(acc && item.cmd == CMD_COUNT),
		.load_sample(acc && item.cmd == CMD_SAMPLE),
		.ctl, .sts, .result(out_ch.data)
	);
endmodule
